FILE: src/bia_pkg.sv
package bia_pkg;

	localparam int MAP_BITS_DEF  = 4096;
	localparam int WORD_BITS_DEF = 32;

	localparam int ID_W     = 16;
	localparam int COUNT_W  = 13;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 16;

	localparam logic [ID_W-1:0]    ID_BASE_RST  = 16'd300;
	localparam logic [COUNT_W-1:0] ID_COUNT_RST = 13'd2701;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd2;

	localparam logic REG_ID_BASE  = 1'b0;
	localparam logic REG_ID_COUNT = 1'b1;

	typedef struct packed {
		logic            op;
		logic [ID_W-1:0] release_id;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]     granted_id;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	typedef struct packed {
		logic found;
		logic last_word;
		logic hit;
	} unit_flags_t;

endpackage

FILE: src/bia_map_ram.sv
module bia_map_ram import bia_pkg::*; #(
	parameter int WORDS = MAP_BITS_DEF / WORD_BITS_DEF,
	parameter int WIDTH = WORD_BITS_DEF,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [WORDS];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/bia_word_unit.sv
module bia_word_unit import bia_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int CNT_W     = 13,
	parameter int BW        = 5
) (
	input  logic                 op,
	input  logic [WORD_BITS-1:0] word,
	input  logic [CNT_W-1:0]     lim,
	input  logic [CNT_W-1:0]     wbase,
	output unit_flags_t          flags,
	output logic [BW-1:0]        off,
	output logic [WORD_BITS-1:0] new_word
);

	logic [CNT_W-1:0]     rem;
	logic [WORD_BITS-1:0] valid_mask;
	logic [WORD_BITS-1:0] free_bits;
	logic [BW-1:0]        first_free;
	logic                 found;
	logic [BW-1:0]        bit_sel;

	// rem is the distance from this word's first bit to the limit: the live
	// identifier count on allocate, the target bit on release.
	always_comb begin
		rem = lim - wbase;
		for (int b = 0; b < WORD_BITS; b++) begin
			valid_mask[b] = (b < int'(rem));
		end
		free_bits = ~word & valid_mask;
		found = 1'b0;
		first_free = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				found = 1'b1;
				first_free = BW'(b);
			end
		end
		flags.found = found;
		flags.last_word = (int'(rem) <= WORD_BITS);
		flags.hit = (int'(rem) < WORD_BITS);
		bit_sel = (op == OP_ALLOC) ? first_free : rem[BW-1:0];
		off = bit_sel;
		new_word = word;
		new_word[bit_sel] = (op == OP_ALLOC);
	end

endmodule

FILE: src/bia_seq.sv
module bia_seq import bia_pkg::*; #(
	parameter int MAP_WORDS = MAP_BITS_DEF / WORD_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int CNT_W     = 13,
	parameter int AW        = 7,
	parameter int BW        = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic [ID_W-1:0]      id_base,
	input  logic [CNT_W-1:0]     live_cnt,
	output logic                 map_we,
	output logic [AW-1:0]        map_waddr,
	output logic [WORD_BITS-1:0] map_wdata,
	output logic [AW-1:0]        map_raddr,
	input  logic [WORD_BITS-1:0] map_rdata,
	output logic                 unit_op,
	output logic [CNT_W-1:0]     unit_lim,
	output logic [CNT_W-1:0]     unit_wbase,
	input  unit_flags_t          unit_flags,
	input  logic [BW-1:0]        unit_off,
	input  logic [WORD_BITS-1:0] unit_new_word
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         w_q;
	logic [CNT_W-1:0]      wbase_q;
	logic [CNT_W-1:0]      lim_q;
	logic                  op_q;
	logic [BW-1:0]         off_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  grant_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  accept;
	logic                  out_free;
	logic [ID_W:0]         rel_diff;
	logic                  rel_bad;
	logic [ID_W-1:0]       grant_sum;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign unit_op    = op_q;
	assign unit_lim   = lim_q;
	assign unit_wbase = wbase_q;

	// A borrow out of the subtraction means the identifier lies below the base.
	assign rel_diff  = {1'b0, in_data.release_id} - {1'b0, id_base};
	assign rel_bad   = rel_diff[ID_W] || (32'(rel_diff[ID_W-1:0]) >= 32'(live_cnt));
	assign grant_sum = ID_W'(32'(id_base) + 32'(wbase_q) + 32'(off_q));

	always_comb begin
		map_we    = 1'b0;
		map_waddr = w_q;
		map_wdata = unit_new_word;
		map_raddr = '0;
		case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_wdata = '0;
			end
			S_SCAN: begin
				map_raddr = AW'(w_q + 1'b1);
				if (op_q == OP_ALLOC) begin
					map_we = unit_flags.found;
				end else begin
					map_we = unit_flags.hit;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			w_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In the response state a drained beat is replaced there, not here.
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					w_q <= AW'(w_q + 1'b1);
					if (w_q == AW'(MAP_WORDS - 1)) begin
						w_q     <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q    <= in_data.op;
						w_q     <= '0;
						wbase_q <= '0;
						grant_q <= 1'b0;
						if (in_data.op == OP_ALLOC) begin
							lim_q <= live_cnt;
							if (live_cnt == '0) begin
								status_q <= ST_FULL;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							lim_q <= CNT_W'(rel_diff[ID_W-1:0]);
							if (rel_bad) begin
								status_q <= ST_BAD_ID;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (op_q == OP_ALLOC && unit_flags.found) begin
						status_q <= ST_OK;
						grant_q  <= 1'b1;
						off_q    <= unit_off;
						state_q  <= S_RESP;
					end else if (op_q == OP_ALLOC && unit_flags.last_word) begin
						status_q <= ST_FULL;
						state_q  <= S_RESP;
					end else if (op_q == OP_RELEASE && unit_flags.hit) begin
						status_q <= ST_OK;
						state_q  <= S_RESP;
					end else begin
						w_q     <= AW'(w_q + 1'b1);
						wbase_q <= CNT_W'(wbase_q + CNT_W'(WORD_BITS));
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_q.granted_id <= grant_q ? grant_sum : '0;
						out_q.status     <= status_q;
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_we_phase: assert property (@(posedge clk) disable iff (!arst_n)
		map_we |-> (state_q == S_CLEAR || state_q == S_SCAN))
		else $error("map written outside the clear pass or the scan");

	a_alloc_sets_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && map_we && op_q == OP_ALLOC)
			|-> ($countones(map_wdata ^ map_rdata) == 1))
		else $error("allocate write does not set exactly one free bit");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && map_we && op_q == OP_RELEASE)
			|-> ((map_wdata & ~map_rdata) == '0))
		else $error("release write sets a bit");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != ST_OK) |-> (out_q.granted_id == '0))
		else $error("failed request carries a nonzero identifier");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (int'(w_q) < MAP_WORDS))
		else $error("scan ran past the last map word");

endmodule

FILE: src/bitmap_id_allocator_top.sv
// First-free identifier allocator over an in-use bitmap kept in a word-wide RAM.
// Input channel (in_valid/in_ready/in_data) carries one request per beat: op selects
// allocate (lowest free identifier) or release (release_id). Output channel
// (out_valid/out_ready/out_data) returns exactly one beat per request with
// granted_id and status. The configuration port (cfg_we/cfg_index/cfg_data) sets
// id_base and id_count and must only be written while no request is in flight.
// One request is handled at a time. A request whose bit lies in map word w reads
// words 0 through w in turn through the single RAM read port and the shared word
// unit in the scan state, between accept in the idle state and the response state.
// An out-of-range release or an allocate with a zero count skips the scan and goes
// from the idle state straight to the response state. The default map holds 4096
// bits as 128 words of 32 bits.
// After reset the map is cleared one word per cycle and in_ready stays low
// meanwhile; configuration writes are taken.
// The result sits in an output register, so a new request is accepted while it
// waits; a request that finishes while the receiver stalls holds until it drains.
module bitmap_id_allocator_top import bia_pkg::*; #(
	parameter int MAP_BITS  = MAP_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int CNT_W     = $clog2(MAP_BITS + 1);

	logic [ID_W-1:0]      id_base_q;
	logic [COUNT_W-1:0]   id_count_q;
	logic [CNT_W-1:0]     live_cnt;

	logic                 map_we;
	logic [AW-1:0]        map_waddr;
	logic [WORD_BITS-1:0] map_wdata;
	logic [AW-1:0]        map_raddr;
	logic [WORD_BITS-1:0] map_rdata;

	logic                 unit_op;
	logic [CNT_W-1:0]     unit_lim;
	logic [CNT_W-1:0]     unit_wbase;
	unit_flags_t          unit_flags;
	logic [BW-1:0]        unit_off;
	logic [WORD_BITS-1:0] unit_new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q  <= ID_BASE_RST;
			id_count_q <= ID_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ID_BASE:  id_base_q  <= cfg_data[ID_W-1:0];
				REG_ID_COUNT: id_count_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Counts above the map size manage only the bits that exist.
	assign live_cnt = (32'(id_count_q) >= MAP_BITS) ? CNT_W'(MAP_BITS) : CNT_W'(id_count_q);

	bia_map_ram #(
		.WORDS (MAP_WORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	bia_word_unit #(
		.WORD_BITS (WORD_BITS),
		.CNT_W     (CNT_W),
		.BW        (BW)
	) u_unit (
		.op       (unit_op),
		.word     (map_rdata),
		.lim      (unit_lim),
		.wbase    (unit_wbase),
		.flags    (unit_flags),
		.off      (unit_off),
		.new_word (unit_new_word)
	);

	bia_seq #(
		.MAP_WORDS (MAP_WORDS),
		.WORD_BITS (WORD_BITS),
		.CNT_W     (CNT_W),
		.AW        (AW),
		.BW        (BW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.id_base       (id_base_q),
		.live_cnt      (live_cnt),
		.map_we        (map_we),
		.map_waddr     (map_waddr),
		.map_wdata     (map_wdata),
		.map_raddr     (map_raddr),
		.map_rdata     (map_rdata),
		.unit_op       (unit_op),
		.unit_lim      (unit_lim),
		.unit_wbase    (unit_wbase),
		.unit_flags    (unit_flags),
		.unit_off      (unit_off),
		.unit_new_word (unit_new_word)
	);

endmodule

FILE: tb/id_grant_checker.sv
`timescale 1ns / 100ps

module id_grant_checker import bia_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_item_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int unsigned      fail_count,
	output int unsigned      pending
);

	localparam int MAP_WORDS = (MAP_BITS_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;

	logic [WORD_BITS_DEF-1:0] shadow_map [MAP_WORDS];
	logic [ID_W-1:0]          base_q;
	logic [COUNT_W-1:0]       count_q;
	out_item_t                expected_grants [$];

	// Works out the answer to one request and applies it to the shadow map.
	function automatic out_item_t predict_grant(in_item_t req);
		int unsigned live;
		int unsigned idx;
		int unsigned hit;
		int unsigned rel;
		int unsigned base;
		bit          found;
		out_item_t   res;
		live = (count_q > MAP_BITS_DEF) ? MAP_BITS_DEF : count_q;
		base = base_q;
		rel = req.release_id;
		res.granted_id = '0;
		res.status = ST_OK;
		if (req.op == OP_ALLOC) begin
			found = 1'b0;
			hit = 0;
			for (idx = 0; idx < live && !found; idx++) begin
				if (!shadow_map[idx / WORD_BITS_DEF][idx % WORD_BITS_DEF]) begin
					found = 1'b1;
					hit = idx;
				end
			end
			if (found) begin
				shadow_map[hit / WORD_BITS_DEF][hit % WORD_BITS_DEF] = 1'b1;
				// The sum may pass 16 bits; only its low bits are granted.
				res.granted_id = ID_W'(base + hit);
			end else begin
				res.status = ST_FULL;
			end
		end else if (rel < base || rel - base >= live) begin
			res.status = ST_BAD_ID;
		end else begin
			idx = rel - base;
			shadow_map[idx / WORD_BITS_DEF][idx % WORD_BITS_DEF] = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			for (int w = 0; w < MAP_WORDS; w++)
				shadow_map[w] = '0;
			base_q = ID_BASE_RST;
			count_q = ID_COUNT_RST;
			expected_grants.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ID_BASE)
					base_q = cfg_data[ID_W-1:0];
				else
					count_q = cfg_data[COUNT_W-1:0];
			end
			// The result beat is matched before this edge's request is queued, so a
			// spurious beat can never pair with a request taken at the same edge.
			if (out_valid && out_ready) begin
				if (expected_grants.size() == 0) begin
					$error("result beat with nothing outstanding: granted_id %0d status %0d",
						out_data.granted_id, out_data.status);
					fail_count++;
				end else begin
					want = expected_grants.pop_front();
					if (out_data.granted_id !== want.granted_id) begin
						$error("granted_id expected %0d actual %0d",
							want.granted_id, out_data.granted_id);
						fail_count++;
					end
					if (out_data.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, out_data.status);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_grants.push_back(predict_grant(in_data));
		end
		pending = expected_grants.size();
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import bia_pkg::*;

	localparam int MAX_GAP       = 13;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AT       = 650;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 140;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned sent_count;
	int unsigned taken_count;
	int unsigned ok_count;
	int unsigned full_count;
	int unsigned bad_count;
	int unsigned setting_count;
	int unsigned next_gap;
	bit          no_idle;
	logic [ID_W-1:0] cur_base;
	int unsigned     cur_live;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bitmap_id_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	id_grant_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic int unsigned draw_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic in_item_t make_req(logic op, logic [ID_W-1:0] id);
		in_item_t req;
		req.op = op;
		req.release_id = id;
		return req;
	endfunction

	function automatic in_item_t random_request();
		in_item_t    req;
		int unsigned roll;
		int unsigned span;
		int unsigned wide;
		roll = $urandom_range(0, 99);
		req.op = OP_RELEASE;
		req.release_id = ID_W'($urandom_range(0, 16'hFFFF));
		if (roll < 55) begin
			req.op = OP_ALLOC;
		end else if (roll < 90 && cur_live != 0) begin
			// Most grants sit at the low end of the range, so aim releases there.
			span = (roll < 75 && cur_live > 64) ? 64 : cur_live;
			wide = cur_base + $urandom_range(0, span - 1);
			req.release_id = ID_W'(wide);
		end else if (roll < 95) begin
			wide = roll[0] ? cur_base + cur_live : cur_base - 1;
			req.release_id = ID_W'(wide);
		end
		return req;
	endfunction

	// Called at a rising edge. Valid is lowered at the accepting edge only when
	// a gap follows, so back-to-back beats keep it high without a glitch.
	task automatic send_request(input in_item_t req);
		logic took;
		repeat (next_gap) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		sent_count++;
		next_gap = draw_gap();
		if (next_gap != 0)
			in_valid <= 1'b0;
	endtask

	task automatic drain_requests();
		if (next_gap == 0)
			in_valid <= 1'b0;
		wait (taken_count == sent_count);
	endtask

	task automatic write_config(input logic idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [CFG_W-1:0] base_value,
			input logic [CFG_W-1:0] count_value);
		drain_requests();
		write_config(REG_ID_BASE, base_value);
		write_config(REG_ID_COUNT, count_value);
		cur_base = base_value;
		cur_live = (count_value[COUNT_W-1:0] > MAP_BITS_DEF) ?
			MAP_BITS_DEF : count_value[COUNT_W-1:0];
		setting_count++;
	endtask

	initial begin : stimulus
		int unsigned p;
		int unsigned k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ID_BASE;
		cfg_data = '0;
		cur_base = ID_BASE_RST;
		cur_live = ID_COUNT_RST;
		no_idle = 1'b0;
		next_gap = 0;
		sent_count = 0;
		setting_count = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting: grants from the base, release of a free id, both range edges.
		send_request(make_req(OP_ALLOC, 16'h0000));
		send_request(make_req(OP_ALLOC, 16'hFFFF));
		send_request(make_req(OP_RELEASE, 16'd300));
		send_request(make_req(OP_RELEASE, 16'd300));
		send_request(make_req(OP_ALLOC, 16'h0000));
		send_request(make_req(OP_RELEASE, 16'd299));
		send_request(make_req(OP_RELEASE, 16'd3000));
		send_request(make_req(OP_RELEASE, 16'd3001));
		send_request(make_req(OP_RELEASE, 16'h0000));
		send_request(make_req(OP_RELEASE, 16'hFFFF));

		// A zero count manages nothing.
		apply_setting(16'd300, 16'd0);
		send_request(make_req(OP_ALLOC, 16'h0000));
		send_request(make_req(OP_RELEASE, 16'd300));

		// Grants reach 65535; a wrapped id such as 0 lies below the base and cannot be released.
		apply_setting(16'hFFFA, 16'd20);
		repeat (6) send_request(make_req(OP_ALLOC, 16'h0000));
		send_request(make_req(OP_RELEASE, 16'hFFFF));
		send_request(make_req(OP_RELEASE, 16'h0000));

		// Count wider than the map is masked and then clamped to the map size.
		apply_setting(16'd0, 16'hFFFF);
		send_request(make_req(OP_RELEASE, 16'd4095));
		send_request(make_req(OP_RELEASE, 16'd4096));
		send_request(make_req(OP_ALLOC, 16'h0000));

		// Base 61439 with a single identifier.
		apply_setting(16'd61439, 16'd1);
		send_request(make_req(OP_ALLOC, 16'h0000));
		send_request(make_req(OP_RELEASE, 16'd61439));
		send_request(make_req(OP_ALLOC, 16'h0000));
		send_request(make_req(OP_ALLOC, 16'h0000));

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: apply_setting(CFG_W'($urandom_range(0, 61439)),
					CFG_W'($urandom_range(1, 48)));
				1: apply_setting(CFG_W'($urandom_range(65000, 65535)),
					CFG_W'($urandom_range(1, 1200)));
				2: apply_setting(CFG_W'($urandom_range(0, 61439)),
					CFG_W'((p == 2) ? 4096 : $urandom_range(4096, 16'hFFFF)));
				default: apply_setting(CFG_W'($urandom_range(0, 61439)),
					CFG_W'($urandom_range(1, 8)));
			endcase
			no_idle = (p % 3 == 2);
			for (k = 0; k < PHASE_ITEMS; k++)
				send_request(random_request());
		end
		no_idle = 1'b0;

		drain_requests();
		repeat (200) @(posedge clk);
		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		$display("Ran %0d requests over %0d register settings, with one long output stall.",
			sent_count, setting_count);
		$display("Answers: %0d ok, %0d full, %0d out of range.", ok_count, full_count, bad_count);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : receiver
		int unsigned gap;
		logic        took;
		out_ready = 1'b0;
		taken_count = 0;
		ok_count = 0;
		full_count = 0;
		bad_count = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// One long hold-off lets the block fill up and stall its input.
			gap = (taken_count == HOLD_AT) ? HOLD_CYCLES : draw_gap();
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				took = out_valid;
				if (took) begin
					if (out_data.status == ST_OK)
						ok_count++;
					else if (out_data.status == ST_FULL)
						full_count++;
					else
						bad_count++;
				end
				@(posedge clk);
			end while (!took);
			taken_count++;
		end
	end

	initial begin : watchdog
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
